// ----- hw/rtl/bucket_ordered_key_set_ranker_top_macros.svh -----
// Assertion macros for the key set ranker.
// Both expect clk and arst_n in scope.
`ifndef BUCKET_ORDERED_KEY_SET_RANKER_TOP_MACROS_SVH
`define BUCKET_ORDERED_KEY_SET_RANKER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BOKR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bokr assertion failed");
`define BOKR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bokr implication failed");
`else
`define BOKR_ASSERT(lbl, prop)
`define BOKR_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/bokr_pkg.sv -----
`default_nettype none
package bokr_pkg;
	localparam int Capacity = 1024;
	localparam int AddrW = $clog2(Capacity);
	localparam int CntW = AddrW + 1;
	localparam logic [24:0] BucketReset = 25'd3000000;
	localparam logic [24:0] BucketMax = 25'h1000000;

	localparam logic [1:0] CMD_INS  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_RANK = 2'd2;
	localparam logic [1:0] CMD_AT   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       scan_rd;
		logic       shift_init;
		logic       shift_step;
		logic       put;
		logic       total_dec;
		logic       rank_rd;
		logic       emit;
		logic [1:0] st;
	} ctl_cmd_t;

	typedef struct packed {
		logic       div_last;
		logic       scan_done;
		logic       found;
		logic       full;
		logic       shift_done;
		logic       rank_bad;
		logic       out_free;
		logic [1:0] cmd;
	} ctl_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bokr_ctrl.sv -----
`default_nettype none
module bokr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  bokr_pkg::ctl_sts_t     sts,
	output bokr_pkg::ctl_cmd_t     cmd_o
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_RRD   = 3'd5;
	localparam logic [2:0] S_RWAIT = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] st_q, st_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd_o   = '0;
		cmd_o.st = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_o.load = 1'b1;
					state_d = S_SCAN;
					if (sts.cmd == bokr_pkg::CMD_INS) state_d = S_DIV;
					else if (sts.cmd == bokr_pkg::CMD_AT) state_d = S_RRD;
				end
			end
			S_DIV: begin
				cmd_o.div_step = 1'b1;
				if (sts.div_last) state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd_o.scan_rd = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FIN;
					priority case (1'b1)
						sts.cmd == bokr_pkg::CMD_RANK:
							st_d = sts.found ? bokr_pkg::ST_OK : bokr_pkg::ST_MISS;
						sts.cmd == bokr_pkg::CMD_INS && sts.found: st_d = bokr_pkg::ST_MISS;
						sts.cmd == bokr_pkg::CMD_INS && sts.full:  st_d = bokr_pkg::ST_FULL;
						sts.cmd == bokr_pkg::CMD_DEL && !sts.found: st_d = bokr_pkg::ST_MISS;
						default: begin
							cmd_o.shift_init = 1'b1;
							st_d = bokr_pkg::ST_OK;
							state_d = S_SHIFT;
						end
					endcase
				end
			end
			S_SHIFT: begin
				cmd_o.shift_step = 1'b1;
				if (sts.shift_done) begin
					if (sts.cmd == bokr_pkg::CMD_INS) begin
						state_d = S_PUT;
					end else begin
						cmd_o.total_dec = 1'b1;
						state_d = S_FIN;
					end
				end
			end
			S_PUT: begin
				cmd_o.put = 1'b1;
				state_d = S_FIN;
			end
			S_RRD: begin
				if (sts.rank_bad) begin
					st_d = bokr_pkg::ST_RANGE;
					state_d = S_FIN;
				end else begin
					cmd_o.rank_rd = 1'b1;
					st_d = bokr_pkg::ST_OK;
					state_d = S_RWAIT;
				end
			end
			S_RWAIT: state_d = S_FIN;
			S_FIN: begin
				if (sts.out_free) begin
					cmd_o.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= bokr_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bokr_dpath.sv -----
`default_nettype none
module bokr_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [24:0]                   cfg_wr_data,
	input  wire logic [1:0]                    cmd,
	input  wire logic [31:0]                   key,
	input  wire logic [bokr_pkg::AddrW-1:0]    rank_in,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [1:0]                         status,
	output logic [bokr_pkg::AddrW-1:0]         rank_out,
	output logic [31:0]                        key_out,
	output logic [bokr_pkg::CntW-1:0]          element_count,
	input  bokr_pkg::ctl_cmd_t                 ctl,
	output bokr_pkg::ctl_sts_t                 sts
);
	localparam int AW = bokr_pkg::AddrW;
	localparam int CW = bokr_pkg::CntW;

	logic [55:0] mem [bokr_pkg::Capacity];
	logic [55:0] rdata_s1;

	logic [24:0]   bcnt_q;
	logic [1:0]    cmd_q;
	logic [31:0]   key_q;
	logic [AW-1:0] rank_q;
	logic [CW-1:0] total_q, idx_q, left_q, at_q;
	logic [AW-1:0] pos_q;
	logic          found_q, atf_q;
	logic [31:0]   dvd_q;
	logic [23:0]   rem_q;
	logic [4:0]    dcnt_q;
	logic          rv_s1, sv_s1;
	logic [AW-1:0] ridx_s1;

	logic [24:0] n_eff, rem_sh;
	logic        scan_go, shift_go, rd_en, ins;
	logic [AW-1:0] rd_addr, sh_waddr;
	logic [31:0] rk;
	logic [23:0] rb;

	assign n_eff = (bcnt_q == '0) ? 25'd1 :
		((bcnt_q > bokr_pkg::BucketMax) ? bokr_pkg::BucketMax : bcnt_q);
	assign rem_sh   = {rem_q, dvd_q[31]};
	assign scan_go  = ctl.scan_rd && (idx_q != total_q);
	assign shift_go = ctl.shift_step && (left_q != '0);
	assign rd_en    = scan_go || shift_go || ctl.rank_rd;
	assign rd_addr  = ctl.rank_rd ? rank_q : idx_q[AW-1:0];
	assign ins      = (cmd_q == bokr_pkg::CMD_INS);
	assign sh_waddr = ins ? ridx_s1 + 1'b1 : ridx_s1 - 1'b1;
	assign rk = rdata_s1[31:0];
	assign rb = rdata_s1[55:32];

	always_ff @(posedge clk) begin
		if (rd_en) rdata_s1 <= mem[rd_addr];
		if (sv_s1) mem[sh_waddr] <= rdata_s1;
		else if (ctl.put) mem[at_q[AW-1:0]] <= {rem_q, key_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q    <= bokr_pkg::BucketReset;
			total_q   <= '0;
			rv_s1     <= 1'b0;
			sv_s1     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) bcnt_q <= cfg_wr_data;
			if (ctl.put) total_q <= total_q + 1'b1;
			else if (ctl.total_dec) total_q <= total_q - 1'b1;
			rv_s1 <= scan_go;
			sv_s1 <= shift_go;
			if (ctl.emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			key_q   <= key;
			rank_q  <= rank_in;
			dvd_q   <= key;
			rem_q   <= '0;
			dcnt_q  <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			atf_q   <= 1'b0;
			at_q    <= total_q;
		end
		if (ctl.div_step) begin
			rem_q  <= (rem_sh >= n_eff) ? 24'(rem_sh - n_eff) : rem_sh[23:0];
			dvd_q  <= {dvd_q[30:0], 1'b0};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (scan_go) idx_q <= idx_q + 1'b1;
		if (rd_en) ridx_s1 <= rd_addr;
		// first matching key, and first entry that sorts after the new key
		if (rv_s1) begin
			if (!found_q && rk == key_q) begin
				found_q <= 1'b1;
				pos_q   <= ridx_s1;
			end
			if (!atf_q && (rb > rem_q || (rb == rem_q && rk > key_q))) begin
				atf_q <= 1'b1;
				at_q  <= {1'b0, ridx_s1};
			end
		end
		if (ctl.shift_init) begin
			if (ins) begin
				idx_q  <= total_q - 1'b1;
				left_q <= total_q - at_q;
			end else begin
				idx_q  <= {1'b0, pos_q} + 1'b1;
				left_q <= total_q - {1'b0, pos_q} - 1'b1;
			end
		end
		if (shift_go) begin
			idx_q  <= ins ? idx_q - 1'b1 : idx_q + 1'b1;
			left_q <= left_q - 1'b1;
		end
		if (ctl.emit) begin
			status        <= ctl.st;
			element_count <= total_q;
			rank_out      <= (cmd_q == bokr_pkg::CMD_RANK && ctl.st == bokr_pkg::ST_OK) ?
				pos_q : '0;
			key_out       <= (cmd_q == bokr_pkg::CMD_AT && ctl.st == bokr_pkg::ST_OK) ?
				rk : '0;
		end
	end

	always_comb begin
		sts.div_last   = (dcnt_q == 5'd31);
		sts.scan_done  = (idx_q == total_q) && !rv_s1;
		sts.found      = found_q;
		sts.full       = (total_q == CW'(bokr_pkg::Capacity));
		sts.shift_done = (left_q == '0) && !sv_s1;
		sts.rank_bad   = ({1'b0, rank_q} >= total_q);
		sts.out_free   = !out_valid || !out_stall;
		sts.cmd        = ctl.load ? cmd : cmd_q;
	end

`include "bucket_ordered_key_set_ranker_top_macros.svh"
	`BOKR_ASSERT(a_total_cap, total_q <= CW'(bokr_pkg::Capacity))
	`BOKR_ASSERT(a_one_read_kind, !(rv_s1 && sv_s1))
	`BOKR_ASSERT(a_put_no_shift, !(ctl.put && sv_s1))
	`BOKR_ASSERT_IMPL(a_put_has_room, ctl.put, total_q < CW'(bokr_pkg::Capacity))
endmodule
`default_nettype wire

// ----- hw/rtl/bucket_ordered_key_set_ranker_top.sv -----
`default_nettype none
// Ordered key set: keys held sorted by bucket (key mod bucket_count) then by key,
// in one 1024 x 56 memory with one read and one write port and registered read
// data; a bucket_count of 0 is taken as 1, one above 2^24 as 2^24. One item is
// in work at a time. Rank-of-key: a scan of all keys held, one entry a cycle.
// Key-at-rank: a single read of the entry at that rank. Delete: a full scan, then
// a shift down of the entries after the deleted key. Insert: a bit-serial
// remainder to find the bucket, a full scan, then a shift up of the entries
// from the insert point and the write. The memory port, one entry a cycle, sets the rate.
// bucket_count may only be written while no item is in work.
module bucket_ordered_key_set_ranker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [24:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] key,
	input  wire logic [9:0]  rank_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [9:0]       rank_out,
	output logic [31:0]      key_out,
	output logic [10:0]      element_count
);
	bokr_pkg::ctl_cmd_t ctl;
	bokr_pkg::ctl_sts_t sts;

	bokr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd_o(ctl)
	);

	bokr_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.cmd(cmd), .key(key), .rank_in(rank_in), .out_stall(out_stall),
		.out_valid(out_valid), .status(status), .rank_out(rank_out),
		.key_out(key_out), .element_count(element_count), .ctl(ctl), .sts(sts)
	);
endmodule
`default_nettype wire
